// ----- rtl/actc_pkg.sv -----
// ----------------------------------------------------------------------------
// actc_pkg
// Shared widths, register indexes and the CORDIC arctangent table for the
// accelerometer calibration and tilt angle block.
// ----------------------------------------------------------------------------
package actc_pkg;

    localparam int RAW_W    = 16;
    localparam int COEF_W   = 20;
    localparam int CAL_W    = 20;
    localparam int REG_W    = 60;
    localparam int ANGLE_W  = 15;
    localparam int ATAN_LEN = 24;
    localparam int ZW       = 26;
    localparam int XYW      = 32;
    localparam int SQ_N     = 28;
    localparam int V_W      = 56;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 15'd23040;

    typedef enum logic [1:0] {
        CFG_ROW0   = 2'd0,
        CFG_ROW1   = 2'd1,
        CFG_ROW2   = 2'd2,
        CFG_OFFSET = 2'd3
    } t_cfg_idx;

    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] v;
        begin
            unique case (idx)
                0:  v = 26'sd2949120;
                1:  v = 26'sd1740967;
                2:  v = 26'sd919879;
                3:  v = 26'sd466945;
                4:  v = 26'sd234379;
                5:  v = 26'sd117304;
                6:  v = 26'sd58666;
                7:  v = 26'sd29335;
                8:  v = 26'sd14668;
                9:  v = 26'sd7334;
                10: v = 26'sd3667;
                11: v = 26'sd1833;
                12: v = 26'sd917;
                13: v = 26'sd458;
                14: v = 26'sd229;
                15: v = 26'sd115;
                16: v = 26'sd57;
                17: v = 26'sd29;
                18: v = 26'sd14;
                19: v = 26'sd7;
                20: v = 26'sd4;
                21: v = 26'sd2;
                22: v = 26'sd1;
                default: v = 26'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/actc_smp_if.sv -----
// ----------------------------------------------------------------------------
// actc_smp_if
// Raw sample channel: valid, ready and three signed axis readings.
// ----------------------------------------------------------------------------
interface actc_smp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [actc_pkg::RAW_W-1:0]      raw_axis0;
    logic signed [actc_pkg::RAW_W-1:0]      raw_axis1;
    logic signed [actc_pkg::RAW_W-1:0]      raw_axis2;

    modport source (output valid, raw_axis0, raw_axis1, raw_axis2, input ready);
    modport sink   (input valid, raw_axis0, raw_axis1, raw_axis2, output ready);
endinterface

// ----- rtl/actc_res_if.sv -----
// ----------------------------------------------------------------------------
// actc_res_if
// Result channel: calibrated axes plus pitch and roll.
// ----------------------------------------------------------------------------
interface actc_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [actc_pkg::CAL_W-1:0]      cal_axis0;
    logic signed [actc_pkg::CAL_W-1:0]      cal_axis1;
    logic signed [actc_pkg::CAL_W-1:0]      cal_axis2;
    logic        [actc_pkg::ANGLE_W-1:0]    pitch_angle;
    logic        [actc_pkg::ANGLE_W-1:0]    roll_angle;

    modport source (output valid, cal_axis0, cal_axis1, cal_axis2, pitch_angle,
                    roll_angle, input ready);
    modport sink   (input valid, cal_axis0, cal_axis1, cal_axis2, pitch_angle,
                    roll_angle, output ready);
endinterface

// ----- rtl/actc_cal_lane.sv -----
// ----------------------------------------------------------------------------
// actc_cal_lane
// One calibration row: three products, offset add, rounding and saturation.
// Two register stages.
// ----------------------------------------------------------------------------
module actc_cal_lane (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [actc_pkg::RAW_W-1:0]   i_raw0,
    input  logic signed [actc_pkg::RAW_W-1:0]   i_raw1,
    input  logic signed [actc_pkg::RAW_W-1:0]   i_raw2,
    input  logic        [actc_pkg::REG_W-1:0]   i_row,
    input  logic signed [actc_pkg::CAL_W-1:0]   i_off,
    output logic signed [actc_pkg::CAL_W-1:0]   o_cal
);

    localparam int PW = actc_pkg::RAW_W + actc_pkg::COEF_W;
    localparam int AW = PW + 3;

    logic signed [PW-1:0] r_p0, r_p1, r_p2;
    logic signed [AW-1:0] acc;
    logic signed [AW-13:0] sh;
    logic signed [actc_pkg::CAL_W-1:0] n_cal;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= i_raw0 * $signed(i_row[19:0]);
            r_p1 <= i_raw1 * $signed(i_row[39:20]);
            r_p2 <= i_raw2 * $signed(i_row[59:40]);
        end
    end

    always_comb begin
        acc = AW'(r_p0) + AW'(r_p1) + AW'(r_p2)
            + (AW'(i_off) <<< 12) + AW'(2048);
        sh  = acc[AW-1:12];
        if (sh > (AW-12)'(524287)) begin
            n_cal = 20'sd524287;
        end else if (sh < -(AW-12)'(524288)) begin
            n_cal = -20'sd524288;
        end else begin
            n_cal = sh[actc_pkg::CAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cal <= n_cal;
        end
    end

endmodule

// ----- rtl/actc_angle_lane.sv -----
// ----------------------------------------------------------------------------
// actc_angle_lane
// One tilt angle: squares, pipelined bit-per-stage square root, then an
// unrolled vectoring CORDIC, one iteration per stage, and a final clamp.
// ----------------------------------------------------------------------------
module actc_angle_lane #(
    parameter int ITER = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [actc_pkg::CAL_W-1:0]   i_num,
    input  logic signed [actc_pkg::CAL_W-1:0]   i_den0,
    input  logic signed [actc_pkg::CAL_W-1:0]   i_den1,
    output logic        [actc_pkg::ANGLE_W-1:0] o_angle
);

    localparam int SN  = actc_pkg::SQ_N;
    localparam int VW  = actc_pkg::V_W;
    localparam int XW  = actc_pkg::XYW;
    localparam int ZW  = actc_pkg::ZW;
    localparam int NW  = actc_pkg::CAL_W;

    logic signed [2*NW-1:0] r_sq0, r_sq1;
    logic        [NW-1:0]   r_n1;
    logic                   r_nz1;
    logic        [NW:0]     num_abs;

    logic [VW-1:0] r_rem  [0:SN];
    logic [SN-1:0] r_root [0:SN];
    logic [NW-1:0] r_sn   [0:SN];
    logic          r_snz  [0:SN];

    logic signed [XW-1:0] c_x [0:ITER-1];
    logic signed [XW-1:0] c_y [0:ITER-1];
    logic signed [ZW-1:0] c_z [0:ITER-1];
    logic                 c_nz[0:ITER-1];
    logic signed [XW-1:0] r_x [1:ITER];
    logic signed [XW-1:0] r_y [1:ITER];
    logic signed [ZW-1:0] r_z [1:ITER];
    logic                 r_nz[1:ITER];

    logic signed [ZW-1:0] zr;
    logic [actc_pkg::ANGLE_W-1:0] n_angle;

    assign num_abs = i_num[NW-1] ? -{i_num[NW-1], i_num} : {1'b0, i_num};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq0 <= i_den0 * i_den0;
            r_sq1 <= i_den1 * i_den1;
            r_n1  <= num_abs[NW-1:0];
            r_nz1 <= (i_num != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {(2*NW)'(r_sq0) + (2*NW)'(r_sq1), 16'b0};
            r_root[0] <= '0;
            r_sn[0]   <= r_n1;
            r_snz[0]  <= r_nz1;
        end
    end

    for (genvar j = 0; j < SN; j++) begin : g_sqrt
        localparam int K = SN - 1 - j;
        logic [VW+1:0] t;
        assign t = ((VW+2)'(r_root[j]) << (K + 1)) + ((VW+2)'(1) << (2 * K));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({2'b0, r_rem[j]} >= t) begin
                    r_rem[j+1]  <= r_rem[j] - t[VW-1:0];
                    r_root[j+1] <= r_root[j] | (SN'(1) << K);
                end else begin
                    r_rem[j+1]  <= r_rem[j];
                    r_root[j+1] <= r_root[j];
                end
                r_sn[j+1]  <= r_sn[j];
                r_snz[j+1] <= r_snz[j];
            end
        end
    end

    for (genvar i = 0; i < ITER; i++) begin : g_cordic
        if (i == 0) begin : g_first
            assign c_x[i]  = XW'(r_root[SN]);
            assign c_y[i]  = XW'({r_sn[SN], 8'b0});
            assign c_z[i]  = '0;
            assign c_nz[i] = r_snz[SN];
        end else begin : g_next
            assign c_x[i]  = r_x[i];
            assign c_y[i]  = r_y[i];
            assign c_z[i]  = r_z[i];
            assign c_nz[i] = r_nz[i];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!c_y[i][XW-1]) begin
                    r_x[i+1] <= c_x[i] + (c_y[i] >>> i);
                    r_y[i+1] <= c_y[i] - (c_x[i] >>> i);
                    r_z[i+1] <= c_z[i] + actc_pkg::atan_q16(i);
                end else begin
                    r_x[i+1] <= c_x[i] - (c_y[i] >>> i);
                    r_y[i+1] <= c_y[i] + (c_x[i] >>> i);
                    r_z[i+1] <= c_z[i] - actc_pkg::atan_q16(i);
                end
                r_nz[i+1] <= c_nz[i];
            end
        end
    end

    always_comb begin
        zr = (r_z[ITER] + ZW'(128)) >>> 8;
        if (!r_nz[ITER] || zr[ZW-1]) begin
            n_angle = '0;
        end else if (zr > ZW'(actc_pkg::ANGLE_MAX)) begin
            n_angle = actc_pkg::ANGLE_MAX;
        end else begin
            n_angle = zr[actc_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= n_angle;
        end
    end

endmodule

// ----- rtl/accel_calibrate_tilt_angles.sv -----
// ----------------------------------------------------------------------------
// accel_calibrate_tilt_angles
// Calibrates a three-axis accelerometer sample and derives pitch and roll.
//
//   channel   dir   handshake          payload
//   i_smp     in    valid/ready        raw_axis0..2
//   o_res     out   valid/ready        cal_axis0..2, pitch_angle, roll_angle
//   cfg       in    i_cfg_we           i_cfg_idx, i_cfg_data
//
// one sample per cycle while the output register is not stalled
// pipeline depth set mainly by the 28-stage square root and one stage per CORDIC iteration
// whole pipeline holds while the output register is full and not taken
// synchronous reset clears valid bits and config registers
// ----------------------------------------------------------------------------
module accel_calibrate_tilt_angles #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [actc_pkg::REG_W-1:0]      i_cfg_data,
    actc_smp_if.sink                        i_smp,
    actc_res_if.source                      o_res
);

    localparam int ALAT = CORDIC_ITERATIONS + 31;
    localparam int LAT  = ALAT + 2;
    localparam int CW   = actc_pkg::CAL_W;

    logic [actc_pkg::REG_W-1:0] r_row0, r_row1, r_row2, r_off;
    logic [LAT-1:0] r_vld;
    logic en;
    logic signed [CW-1:0] cal0, cal1, cal2;
    logic signed [CW-1:0] r_d0 [0:ALAT-1];
    logic signed [CW-1:0] r_d1 [0:ALAT-1];
    logic signed [CW-1:0] r_d2 [0:ALAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= '0;
            r_row1 <= '0;
            r_row2 <= '0;
            r_off  <= '0;
        end else if (i_cfg_we) begin
            unique case (actc_pkg::t_cfg_idx'(i_cfg_idx))
                actc_pkg::CFG_ROW0:   r_row0 <= i_cfg_data;
                actc_pkg::CFG_ROW1:   r_row1 <= i_cfg_data;
                actc_pkg::CFG_ROW2:   r_row2 <= i_cfg_data;
                actc_pkg::CFG_OFFSET: r_off  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en          = !r_vld[LAT-1] || o_res.ready;
    assign i_smp.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_smp.valid};
        end
    end

    actc_cal_lane u_cal0 (
        .i_clk(i_clk), .i_en(en), .i_raw0(i_smp.raw_axis0), .i_raw1(i_smp.raw_axis1),
        .i_raw2(i_smp.raw_axis2), .i_row(r_row0), .i_off(r_off[19:0]), .o_cal(cal0)
    );
    actc_cal_lane u_cal1 (
        .i_clk(i_clk), .i_en(en), .i_raw0(i_smp.raw_axis0), .i_raw1(i_smp.raw_axis1),
        .i_raw2(i_smp.raw_axis2), .i_row(r_row1), .i_off(r_off[39:20]), .o_cal(cal1)
    );
    actc_cal_lane u_cal2 (
        .i_clk(i_clk), .i_en(en), .i_raw0(i_smp.raw_axis0), .i_raw1(i_smp.raw_axis1),
        .i_raw2(i_smp.raw_axis2), .i_row(r_row2), .i_off(r_off[59:40]), .o_cal(cal2)
    );

    actc_angle_lane #(.ITER(CORDIC_ITERATIONS)) u_pitch (
        .i_clk(i_clk), .i_en(en), .i_num(cal1), .i_den0(cal0), .i_den1(cal2),
        .o_angle(o_res.pitch_angle)
    );
    actc_angle_lane #(.ITER(CORDIC_ITERATIONS)) u_roll (
        .i_clk(i_clk), .i_en(en), .i_num(cal0), .i_den0(cal1), .i_den1(cal2),
        .o_angle(o_res.roll_angle)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d0[0] <= cal0;
            r_d1[0] <= cal1;
            r_d2[0] <= cal2;
            for (int k = 1; k < ALAT; k++) begin
                r_d0[k] <= r_d0[k-1];
                r_d1[k] <= r_d1[k-1];
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    assign o_res.valid     = r_vld[LAT-1];
    assign o_res.cal_axis0 = r_d0[ALAT-1];
    assign o_res.cal_axis1 = r_d1[ALAT-1];
    assign o_res.cal_axis2 = r_d2[ALAT-1];

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.pitch_angle <= actc_pkg::ANGLE_MAX)
        else $error("pitch out of range");
    a_pitch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.cal_axis1 == '0) |-> o_res.pitch_angle == '0)
        else $error("pitch nonzero for zero axis 1");
    a_roll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.cal_axis0 == '0) |-> o_res.roll_angle == '0)
        else $error("roll nonzero for zero axis 0");
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("valid after reset");

endmodule
